// ----- hw/rtl/mm4_pkg.sv -----
// ----------------------------------------------------------------------------
// mm4_pkg
// shared types and constants for the 4x4 matrix multiplier
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned HalfDepth = 16;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned AccW      = 2 * DataW + 2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } mm4_state_e;

  // tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last;
    logic [IdxW-1:0] index;
  } mm4_tag_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mm4_ram.sv -----
// ----------------------------------------------------------------------------
// mm4_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mm4_seq.sv -----
// ----------------------------------------------------------------------------
// mm4_seq
// load counter, control state machine and read address generation
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_seq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic                      fin_i,
  output logic                           busy_o,
  output logic                           we_a_o,
  output logic                           we_b_o,
  output logic      [mm4_pkg::AddrW-1:0] waddr_o,
  output logic      [mm4_pkg::AddrW-1:0] raddr_a_o,
  output logic      [mm4_pkg::AddrW-1:0] raddr_b_o,
  output mm4_pkg::mm4_tag_t              tag_o
);

  mm4_pkg::mm4_state_e state_q, state_d;
  logic [mm4_pkg::AddrW:0]     load_q, load_d;
  logic [2*mm4_pkg::AddrW-3:0] step_q, step_d;
  mm4_pkg::mm4_tag_t           tag_q, tag_d;
  logic                        accept;

  assign accept = start_i & (state_q == mm4_pkg::ST_LOAD);
  assign busy_o = (state_q != mm4_pkg::ST_LOAD);

  assign we_a_o  = accept & ~load_q[mm4_pkg::AddrW];
  assign we_b_o  = accept & load_q[mm4_pkg::AddrW];
  assign waddr_o = load_q[mm4_pkg::AddrW-1:0];

  // step = {i, j, k}
  assign raddr_a_o = {step_q[5:4], step_q[1:0]};
  assign raddr_b_o = {step_q[1:0], step_q[3:2]};

  always_comb begin
    state_d = state_q;
    load_d  = load_q;
    step_d  = step_q;
    tag_d   = '0;
    case (state_q)
      mm4_pkg::ST_LOAD: begin
        if (accept) begin
          load_d = load_q + 1'b1;
          if (&load_q) begin
            state_d = mm4_pkg::ST_RUN;
            step_d  = '0;
          end
        end
      end
      mm4_pkg::ST_RUN: begin
        tag_d.valid = 1'b1;
        tag_d.first = (step_q[1:0] == 2'd0);
        tag_d.last  = (step_q[1:0] == 2'd3);
        tag_d.index = step_q[5:2];
        step_d      = step_q + 1'b1;
        if (&step_q) begin
          state_d = mm4_pkg::ST_DRAIN;
        end
      end
      mm4_pkg::ST_DRAIN: begin
        if (fin_i) begin
          state_d = mm4_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = mm4_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm4_pkg::ST_LOAD;
      load_q  <= '0;
      step_q  <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      step_q  <= step_d;
      tag_q   <= tag_d;
    end
  end

  // tag lines up with the registered ram read data
  assign tag_o = tag_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mm4_mac.sv -----
// ----------------------------------------------------------------------------
// mm4_mac
// multiply, accumulate over k, shift and saturate one product element
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_mac #(
  parameter int unsigned FracBits = mm4_pkg::FracBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic      [mm4_pkg::DataW-1:0] a_i,
  input  wire logic      [mm4_pkg::DataW-1:0] b_i,
  input  wire mm4_pkg::mm4_tag_t              tag_i,
  output logic                                fin_o,
  output logic                                valid_o,
  output logic signed    [mm4_pkg::DataW-1:0] product_element_o,
  output logic           [mm4_pkg::IdxW-1:0]  product_index_o,
  output logic                                last_of_matrix_o
);

  localparam int unsigned AccW  = mm4_pkg::AccW;
  localparam int unsigned ProdW = 2 * mm4_pkg::DataW;

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d, prod_ext, shifted;
  mm4_pkg::mm4_tag_t       ptag_q, atag_q;
  logic                    done;
  logic                    in_range;
  logic [mm4_pkg::DataW-1:0] sat;
  logic                    valid_q, last_q;
  logic [mm4_pkg::DataW-1:0] elem_q;
  logic [mm4_pkg::IdxW-1:0]  idx_q;

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_i) * $signed(b_i);
  end

  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign acc_d    = ptag_q.first ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i) begin
    if (ptag_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign shifted  = acc_q >>> FracBits;
  assign in_range = (&shifted[AccW-1:mm4_pkg::DataW-1])
                  | ~(|shifted[AccW-1:mm4_pkg::DataW-1]);
  assign sat = in_range ? shifted[mm4_pkg::DataW-1:0]
             : (shifted[AccW-1] ? {1'b1, {(mm4_pkg::DataW-1){1'b0}}}
                                : {1'b0, {(mm4_pkg::DataW-1){1'b1}}});

  assign done  = atag_q.valid & atag_q.last;
  assign fin_o = done & (&atag_q.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptag_q  <= '0;
      atag_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      ptag_q  <= tag_i;
      atag_q  <= ptag_q;
      valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      elem_q <= sat;
      idx_q  <= atag_q.index;
      last_q <= &atag_q.index;
    end
  end

  assign valid_o           = valid_q;
  assign product_element_o = elem_q;
  assign product_index_o   = idx_q;
  assign last_of_matrix_o  = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/matrix4x4_multiply_top.sv -----
// ----------------------------------------------------------------------------
// matrix4x4_multiply_top
// 4x4 signed fixed point matrix multiply, C = A * B
// ----------------------------------------------------------------------------
// usage:
//   a request is taken at a rising edge with start_i high and busy_o low;
//   element_value_i carries one element, 16 of A then 16 of B, row-major
//   each element is written to the A or B ram at the edge that takes it
//   after the 32nd element busy_o rises and the 64 multiply-accumulate
//   steps run through one shared multiplier, one step per cycle, with
//   operands read from the two rams
//   results leave in row-major order, each on valid_o for one cycle with
//   product_index_o and last_of_matrix_o; they cannot be held off
//   each result follows its four multiply-accumulate steps through the tag
//   and ram read, product, accumulator and output registers
//   busy_o falls as the last result is written to the output registers
//   reset clears the load counter and control; ram contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4x4_multiply_top #(
  parameter int unsigned FracBits = mm4_pkg::FracBits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic signed [mm4_pkg::DataW-1:0] element_value_i,
  output logic                                  valid_o,
  output logic signed      [mm4_pkg::DataW-1:0] product_element_o,
  output logic             [mm4_pkg::IdxW-1:0]  product_index_o,
  output logic                                  last_of_matrix_o
);

  logic                      we_a, we_b, fin;
  logic [mm4_pkg::AddrW-1:0] waddr, raddr_a, raddr_b;
  logic [mm4_pkg::DataW-1:0] rdata_a, rdata_b;
  mm4_pkg::mm4_tag_t         tag;

  mm4_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .fin_i     (fin),
    .busy_o    (busy_o),
    .we_a_o    (we_a),
    .we_b_o    (we_b),
    .waddr_o   (waddr),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .tag_o     (tag)
  );

  mm4_ram #(
    .Width (mm4_pkg::DataW),
    .Depth (mm4_pkg::HalfDepth)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mm4_ram #(
    .Width (mm4_pkg::DataW),
    .Depth (mm4_pkg::HalfDepth)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  mm4_mac #(
    .FracBits (FracBits)
  ) u_mac (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .a_i               (rdata_a),
    .b_i               (rdata_b),
    .tag_i             (tag),
    .fin_o             (fin),
    .valid_o           (valid_o),
    .product_element_o (product_element_o),
    .product_index_o   (product_index_o),
    .last_of_matrix_o  (last_of_matrix_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for matrix4x4_multiply_top
// loads 4x4 matrix pairs one element per request, predicts each product
// element with a full-width dot product, floor shift and saturation, and
// checks every strobed result in order; a directed pair of extremes comes
// first, then random pairs with random sender gaps
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned DataW     = mm4_pkg::DataW;
  localparam int unsigned IdxW      = mm4_pkg::IdxW;
  localparam int unsigned HalfDepth = mm4_pkg::HalfDepth;
  localparam int unsigned FracBits  = mm4_pkg::FracBits;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomPairs = 11;

  localparam logic signed [DataW-1:0] ElemMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] ElemMin = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] ElemOne = 32'sh0001_0000;
  localparam logic signed [DataW-1:0] ElemLsbNeg = -32'sd1;

  localparam logic signed [65:0] SumHi = 66'sd2147483647;
  localparam logic signed [65:0] SumLo = -66'sd2147483648;

  typedef enum int {
    FILL_SMALL,
    FILL_FULL,
    FILL_EXTREME,
    FILL_LARGE
  } fill_style_e;

  typedef struct {
    logic signed [DataW-1:0] element;
    logic [IdxW-1:0]         index;
    logic                    last;
  } product_t;

  typedef struct {
    logic                    known;
    logic signed [DataW-1:0] element;
  } product_hint_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start_i;
  logic signed [DataW-1:0] element_value_i;
  logic                    busy_o;
  logic                    valid_o;
  logic signed [DataW-1:0] product_element_o;
  logic [IdxW-1:0]         product_index_o;
  logic                    last_of_matrix_o;

  // directed pair: A then B, row-major
  logic signed [DataW-1:0] directed_elements [32] = '{
    ElemMax, ElemMax, ElemMax, ElemMax,
    ElemMin, ElemMin, ElemMin, ElemMin,
    ElemOne, 32'sd0, 32'sd0, 32'sd0,
    ElemLsbNeg, 32'sd0, 32'sd0, 32'sd0,
    ElemMax, ElemMin, ElemOne, 32'sd0,
    ElemMax, ElemMin, 32'sd0, 32'sd0,
    ElemMax, ElemMin, 32'sd0, 32'sd0,
    ElemMax, ElemMin, 32'sd0, 32'sd0
  };

  // products of the directed pair that are plain to see
  product_hint_t directed_products [16] = '{
    '{1'b1, ElemMax}, '{1'b1, ElemMin}, '{1'b1, ElemMax}, '{1'b1, 32'sd0},
    '{1'b1, ElemMin}, '{1'b1, ElemMax}, '{1'b1, ElemMin}, '{1'b1, 32'sd0},
    '{1'b1, ElemMax}, '{1'b1, ElemMin}, '{1'b1, ElemOne}, '{1'b1, 32'sd0},
    '{1'b0, 32'sd0},  '{1'b1, 32'sh0000_8000}, '{1'b1, ElemLsbNeg}, '{1'b1, 32'sd0}
  };

  logic signed [DataW-1:0] element_store [32];
  logic [5:0]              load_count;
  product_t                pending_products [$];
  int unsigned             pairs_loaded;
  int unsigned             elements_loaded;
  int unsigned             products_checked;
  int unsigned             failures;
  int unsigned             stall_cycles;

  matrix4x4_multiply_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .element_value_i   (element_value_i),
    .valid_o           (valid_o),
    .product_element_o (product_element_o),
    .product_index_o   (product_index_o),
    .last_of_matrix_o  (last_of_matrix_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [DataW-1:0] dot_product(input int row, input int col);
    logic signed [65:0] acc;
    logic signed [65:0] lhs;
    logic signed [65:0] rhs;
    logic signed [65:0] scaled;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      lhs = element_store[row * 4 + k];
      rhs = element_store[HalfDepth + k * 4 + col];
      acc = acc + lhs * rhs;
    end
    scaled = acc >>> FracBits;
    if (scaled > SumHi) begin
      return ElemMax;
    end else if (scaled < SumLo) begin
      return ElemMin;
    end
    return scaled[DataW-1:0];
  endfunction

  task automatic store_element(input logic signed [DataW-1:0] value);
    product_t prod;
    element_store[load_count[4:0]] = value;
    elements_loaded++;
    if (load_count == 6'd31) begin
      load_count = '0;
      for (int n = 0; n < 16; n++) begin
        if (pairs_loaded == 0 && directed_products[n].known) begin
          prod.element = directed_products[n].element;
        end else begin
          prod.element = dot_product(n / 4, n % 4);
        end
        prod.index = IdxW'(n);
        prod.last  = (n == 15);
        pending_products.push_back(prod);
      end
      pairs_loaded++;
    end else begin
      load_count = load_count + 6'd1;
    end
  endtask

  task automatic check_product();
    product_t want;
    if (pending_products.size() == 0) begin
      $error("product with no request pending: index %0d value %h",
             product_index_o, product_element_o);
      failures++;
    end else begin
      want = pending_products.pop_front();
      products_checked++;
      if (product_element_o !== want.element) begin
        $error("product_element: expected %h, got %h", want.element, product_element_o);
        failures++;
      end
      if (product_index_o !== want.index) begin
        $error("product_index: expected %0d, got %0d", want.index, product_index_o);
        failures++;
      end
      if (last_of_matrix_o !== want.last) begin
        $error("last_of_matrix: expected %0b, got %0b", want.last, last_of_matrix_o);
        failures++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        check_product();
      end
      if (start_i && !busy_o) begin
        store_element(element_value_i);
      end
      if ((start_i && !busy_o) || valid_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("timeout: nothing accepted for %0d cycles", StallLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic signed [DataW-1:0] random_element(input fill_style_e style);
    logic [DataW-1:0] raw;
    raw = $urandom;
    case (style)
      FILL_SMALL: begin
        return DataW'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      end
      FILL_EXTREME: begin
        case ($urandom_range(0, 5))
          0: return ElemMax;
          1: return ElemMin;
          2: return 32'sd0;
          3: return ElemOne;
          4: return ElemLsbNeg;
          default: return raw;
        endcase
      end
      FILL_LARGE: begin
        raw[30] = ~raw[31];
        return raw;
      end
      default: return raw;
    endcase
  endfunction

  task automatic send_element(input logic signed [DataW-1:0] value);
    start_i         <= 1'b1;
    element_value_i <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_for_products();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_products.size() != 0);
  endtask

  initial begin
    fill_style_e style;
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    element_value_i  = '0;
    load_count       = '0;
    pairs_loaded     = 0;
    elements_loaded  = 0;
    products_checked = 0;
    failures         = 0;
    stall_cycles     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_elements[n]) begin
      if ($urandom_range(0, 7) == 0) hold_off($urandom_range(1, 18));
      send_element(directed_elements[n]);
    end
    wait_for_products();

    for (int p = 0; p < RandomPairs; p++) begin
      style = fill_style_e'($urandom_range(FILL_SMALL, FILL_LARGE));
      if (p == RandomPairs / 2) wait_for_products();
      for (int e = 0; e < 32; e++) begin
        // no gaps in the last two pairs
        if (p < RandomPairs - 2 && $urandom_range(0, 5) == 0) begin
          hold_off($urandom_range(1, 18));
        end
        send_element(random_element(style));
      end
    end

    wait_for_products();
    repeat (DrainCycles) @(posedge clk_i);

    $display("loaded %0d elements in %0d matrix pairs, one pair of extremes",
             elements_loaded, pairs_loaded);
    $display("checked %0d product elements against the predicted values",
             products_checked);
    if (failures == 0 && pending_products.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
